[sv/oas_pkg.sv]
// Shared defaults, request codes and status codes for the ordered array store.
`timescale 1ns / 1ps

package oas_pkg;

  localparam int unsigned DefaultDepth    = 16;
  localparam int unsigned DefaultWordBits = 32;

  // Fixed field widths of the request and result beats.
  localparam int unsigned OpBits     = 3;
  localparam int unsigned PosBits    = 5;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 5;

  typedef enum logic [OpBits-1:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

[sv/oas_ram.sv]
// Word store with one write port and one registered read port.
`timescale 1ns / 1ps

module oas_ram #(
  parameter int unsigned DEPTH     = oas_pkg::DefaultDepth,
  parameter int unsigned WORD_BITS = oas_pkg::DefaultWordBits,
  localparam int unsigned AddrW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ordered_array_store_unit.sv]
// Top level of the ordered array store: request sequencer around a word store with one write port and one read port.
`timescale 1ns / 1ps

// A request beat is taken when start is high and busy is low; its result appears later, on
// done_o for exactly one cycle, and must be captured then because the receiver cannot hold
// it off. Append, write, unused codes and every rejected request finish from S_EXEC, read
// and remove-last pass through S_RDWAIT, and insert or erase step through S_UP and S_UPWR
// or S_DOWN and S_DOWNWR once for each word moved up or down. Each such move is a read
// through the word store's registered port followed by a write. Busy stays high throughout,
// so no new request is taken before the one in progress is done.
module ordered_array_store_unit #(
  parameter int unsigned DEPTH     = oas_pkg::DefaultDepth,
  parameter int unsigned WORD_BITS = oas_pkg::DefaultWordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [oas_pkg::OpBits-1:0]     operation_i,
  input  logic [oas_pkg::PosBits-1:0]    position_i,
  input  logic [oas_pkg::ValueBits-1:0]  value_i,
  output logic                           done_o,
  output logic [oas_pkg::ValueBits-1:0]  read_value_o,
  output logic [oas_pkg::StatusBits-1:0] status_o,
  output logic [oas_pkg::CountBits-1:0]  count_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > oas_pkg::PosBits) ? CntW : oas_pkg::PosBits;
  localparam int unsigned OutCW = (CntW > oas_pkg::CountBits) ? CntW : oas_pkg::CountBits;
  localparam int unsigned MaxW  = (WORD_BITS > oas_pkg::ValueBits) ? WORD_BITS
                                                                   : oas_pkg::ValueBits;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_UP,
    S_UPWR,
    S_DOWN,
    S_DOWNWR
  } state_e;

  state_e               state_q;
  oas_pkg::op_e         op_q;
  logic [CmpW-1:0]      pos_q;
  logic [WORD_BITS-1:0] val_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      idx_q;
  logic [WORD_BITS-1:0] rdv_q;
  oas_pkg::status_e     status_q;
  logic                 done_q;

  logic [MaxW-1:0]      val_ext;
  logic [MaxW-1:0]      rdv_ext;
  logic [OutCW-1:0]     cnt_ext;
  logic [CmpW-1:0]      cnt_cmp;
  logic [CmpW-1:0]      idx_cmp;
  logic [CntW-1:0]      cnt_dec;
  logic [CntW-1:0]      idx_inc;
  logic [CntW-1:0]      idx_dec;
  logic                 full;
  logic                 pos_gt_cnt;
  logic                 pos_ge_cnt;
  logic                 idx_gt_pos;
  logic                 down_more;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AddrW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign val_ext    = MaxW'(value_i);
  assign rdv_ext    = MaxW'(rdv_q);
  assign cnt_ext    = OutCW'(cnt_q);
  assign cnt_cmp    = CmpW'(cnt_q);
  assign idx_cmp    = CmpW'(idx_q);
  assign cnt_dec    = cnt_q - 1'b1;
  assign idx_inc    = idx_q + 1'b1;
  assign idx_dec    = idx_q - 1'b1;
  assign full       = (cnt_q == CntW'(DEPTH));
  assign pos_gt_cnt = (pos_q > cnt_cmp);
  assign pos_ge_cnt = (pos_q >= cnt_cmp);
  assign idx_gt_pos = (idx_cmp > pos_q);
  assign down_more  = (idx_inc < cnt_q);

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign read_value_o = rdv_ext[oas_pkg::ValueBits-1:0];
  assign status_o     = status_q;
  assign count_o      = cnt_ext[oas_pkg::CountBits-1:0];

  // Word store port control; the read address is only meaningful where its data is used.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AddrW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_dec[AddrW-1:0];
    case (state_q)
      S_EXEC: begin
        case (op_q)
          oas_pkg::OP_APPEND: begin
            ram_we    = !full;
            ram_waddr = cnt_q[AddrW-1:0];
            ram_wdata = val_q;
          end
          oas_pkg::OP_POP: begin
            ram_raddr = cnt_dec[AddrW-1:0];
          end
          oas_pkg::OP_READ: begin
            ram_raddr = pos_q[AddrW-1:0];
          end
          oas_pkg::OP_WRITE: begin
            ram_we    = !pos_ge_cnt;
            ram_waddr = pos_q[AddrW-1:0];
            ram_wdata = val_q;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      S_UP: begin
        // Once the gap has reached the position, the new word drops into it.
        if (!idx_gt_pos) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AddrW-1:0];
          ram_wdata = val_q;
        end
      end
      S_UPWR: begin
        ram_we = 1'b1;
      end
      S_DOWN: begin
        ram_raddr = idx_inc[AddrW-1:0];
      end
      S_DOWNWR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  oas_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= oas_pkg::ST_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q    <= oas_pkg::op_e'(operation_i);
            pos_q   <= CmpW'(position_i);
            val_q   <= val_ext[WORD_BITS-1:0];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            oas_pkg::OP_APPEND: begin
              done_q  <= 1'b1;
              rdv_q   <= '0;
              state_q <= S_IDLE;
              if (full) begin
                status_q <= oas_pkg::ST_FULL;
              end else begin
                status_q <= oas_pkg::ST_OK;
                cnt_q    <= cnt_q + 1'b1;
              end
            end
            oas_pkg::OP_POP: begin
              if (cnt_q == '0) begin
                done_q   <= 1'b1;
                rdv_q    <= '0;
                status_q <= oas_pkg::ST_EMPTY;
                state_q  <= S_IDLE;
              end else begin
                cnt_q   <= cnt_dec;
                state_q <= S_RDWAIT;
              end
            end
            oas_pkg::OP_INSERT: begin
              if (pos_gt_cnt || full) begin
                done_q   <= 1'b1;
                rdv_q    <= '0;
                status_q <= pos_gt_cnt ? oas_pkg::ST_RANGE : oas_pkg::ST_FULL;
                state_q  <= S_IDLE;
              end else begin
                idx_q   <= cnt_q;
                state_q <= S_UP;
              end
            end
            oas_pkg::OP_ERASE: begin
              if (pos_ge_cnt) begin
                done_q   <= 1'b1;
                rdv_q    <= '0;
                status_q <= oas_pkg::ST_RANGE;
                state_q  <= S_IDLE;
              end else begin
                idx_q   <= pos_q[CntW-1:0];
                state_q <= S_DOWN;
              end
            end
            oas_pkg::OP_READ: begin
              if (pos_ge_cnt) begin
                done_q   <= 1'b1;
                rdv_q    <= '0;
                status_q <= oas_pkg::ST_RANGE;
                state_q  <= S_IDLE;
              end else begin
                state_q <= S_RDWAIT;
              end
            end
            oas_pkg::OP_WRITE: begin
              done_q   <= 1'b1;
              rdv_q    <= '0;
              status_q <= pos_ge_cnt ? oas_pkg::ST_RANGE : oas_pkg::ST_OK;
              state_q  <= S_IDLE;
            end
            default: begin
              // Unused request codes leave the stored words and the count as they are.
              done_q   <= 1'b1;
              rdv_q    <= '0;
              status_q <= oas_pkg::ST_OK;
              state_q  <= S_IDLE;
            end
          endcase
        end
        S_RDWAIT: begin
          done_q   <= 1'b1;
          rdv_q    <= ram_rdata;
          status_q <= oas_pkg::ST_OK;
          state_q  <= S_IDLE;
        end
        S_UP: begin
          if (idx_gt_pos) begin
            state_q <= S_UPWR;
          end else begin
            cnt_q    <= cnt_q + 1'b1;
            done_q   <= 1'b1;
            rdv_q    <= '0;
            status_q <= oas_pkg::ST_OK;
            state_q  <= S_IDLE;
          end
        end
        S_UPWR: begin
          idx_q   <= idx_dec;
          state_q <= S_UP;
        end
        S_DOWN: begin
          if (down_more) begin
            state_q <= S_DOWNWR;
          end else begin
            cnt_q    <= cnt_dec;
            done_q   <= 1'b1;
            rdv_q    <= '0;
            status_q <= oas_pkg::ST_OK;
            state_q  <= S_IDLE;
          end
        end
        S_DOWNWR: begin
          idx_q   <= idx_inc;
          state_q <= S_DOWN;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // A result only ever closes a request that was in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a request in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("stored word count beyond capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == oas_pkg::ST_FULL) |-> full)
    else $error("full status reported while space remains");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted request did not raise busy");

endmodule
